// ===== hw/rtl/mp3si_pkg.sv =====
// Package for the MPEG-1 Layer III side-information parser.
// Holds field widths, frame constants, the granule record type and its unpacker.
// No dependencies.
`default_nettype none

package mp3si_pkg;

	localparam int unsigned BUF_BITS    = 72;
	localparam int unsigned CNT_W       = 7;
	localparam int unsigned REC_BITS    = 59;
	localparam int unsigned OUT_DATA_W  = 88;
	localparam int unsigned OUT_USER_W  = 2;

	localparam logic [CNT_W-1:0] BYTE_BITS      = 7'd8;
	localparam logic [CNT_W-1:0] HDR_BITS_MONO  = 7'd18;
	localparam logic [CNT_W-1:0] HDR_BITS_STRO  = 7'd20;
	localparam logic [CNT_W-1:0] REC_BITS_C     = 7'd59;
	localparam logic [2:0]       RECS_MONO      = 3'd2;
	localparam logic [2:0]       RECS_STRO      = 3'd4;
	localparam logic [1:0]       BT_SHORT       = 2'd2;
	localparam logic [3:0]       R0_SHORT       = 4'd8;
	localparam logic [3:0]       R0_OTHER       = 4'd7;
	localparam logic [4:0]       REGION_SUM     = 5'd20;

	typedef struct packed {
		logic [11:0] part2_3_length;
		logic [8:0]  big_values;
		logic [7:0]  global_gain;
		logic [3:0]  scalefac_compress;
		logic [1:0]  block_type;
		logic [4:0]  flags;
		logic [14:0] table_selects;
		logic [8:0]  subblock_gains;
		logic [7:0]  region_counts;
	} gr_rec_t;

	// Split one 59-bit granule/channel record, first bit in bit 58.
	function automatic gr_rec_t unpack_record(input logic [REC_BITS-1:0] r);
		gr_rec_t    o;
		logic       ws;
		logic       mixed;
		logic [1:0] bt;
		logic [3:0] r0;
		logic [4:0] r1;
		ws    = r[25];
		bt    = r[24:23];
		mixed = r[22];
		o.part2_3_length    = r[58:47];
		o.big_values        = r[46:38];
		o.global_gain       = r[37:30];
		o.scalefac_compress = r[29:26];
		if (ws) begin
			r0 = (bt == BT_SHORT && !mixed) ? R0_SHORT : R0_OTHER;
			r1 = REGION_SUM - {1'b0, r0};
			o.block_type     = bt;
			o.flags          = {1'b1, mixed, r[2:0]};
			o.table_selects  = {r[21:12], 5'd0};
			o.subblock_gains = r[11:3];
			o.region_counts  = {r0, r1[3:0]};
		end else begin
			o.block_type     = 2'd0;
			o.flags          = {2'b00, r[2:0]};
			o.table_selects  = r[24:10];
			o.subblock_gains = 9'd0;
			o.region_counts  = {r[9:6], 1'b0, r[5:3]};
		end
		return o;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mp3_side_info_parser.sv =====
// MPEG-1 Layer III side-information parser, top level.
// Uses mp3si_pkg for constants, the record type and the record unpacker.
// Usage:
//   Slave stream: one side-info byte per request, MSB first. tuser[0] marks
//   the first byte of a frame and restarts the parse; tuser[1] is the mono
//   flag, sampled with that first byte. Mono frames use 17 bytes, stereo 32.
//   Bytes outside a frame (before a start, or after the last record) are
//   accepted and dropped.
//   Master stream: one request per granule/channel record, emitted for the
//   byte that completes it; tuser carries the slot (granule*2 + channel).
//   Pipeline: input register, then result register; the record is written to the
//   result register when its last byte advances out of the input register.
//   Throughput: one byte per cycle while the receiver does not stall; the 72-bit
//   bit buffer and its counter are updated once per accepted in-frame byte.
//   Reset clears the pipeline valids and all parse state but the bit buffer; no frame is active.
//   When the receiver stalls, the held record stays valid, the input
//   register takes at most one more byte and then tready stays low.
`default_nettype none

module mp3_side_info_parser
	import mp3si_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// [7:0] data_byte
	input  wire logic [7:0]            s_axis_tdata,
	// [0] frame_start, [1] mono
	input  wire logic [1:0]            s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// [8:0] main_data_begin, [12:9] scfsi, [24:13] part2_3_length,
	// [33:25] big_values, [41:34] global_gain, [45:42] scalefac_compress,
	// [47:46] block_type, [52:48] flags, [67:53] table_selects,
	// [76:68] subblock_gains, [84:77] region_counts, [87:85] zero
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	// [1:0] slot
	output logic [OUT_USER_W-1:0]      m_axis_tuser
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic [1:0]            user_s1;

	logic [BUF_BITS-1:0]   buf_q;
	logic [CNT_W-1:0]      bit_count_q;
	logic                  header_done_q;
	logic [2:0]            next_slot_q;
	logic                  mono_q;
	logic                  active_q;
	logic [8:0]            mdb_q;
	logic [7:0]            scfsi_q;

	logic                  valid_s2;
	logic [OUT_DATA_W-1:0] data_s2;
	logic [OUT_USER_W-1:0] user_s2;

	logic                  s2_free;
	logic                  adv;
	logic                  start;
	logic                  act;
	logic [CNT_W-1:0]      bc0;
	logic [CNT_W-1:0]      bc1;
	logic [CNT_W-1:0]      bc2;
	logic                  hd0;
	logic [2:0]            ns0;
	logic                  mm;
	logic [CNT_W-1:0]      hdr_len;
	logic [2:0]            recs;
	logic [BUF_BITS-1:0]   buf_n;
	logic                  hdr_take;
	logic                  rec_take;
	logic [BUF_BITS-1:0]   hdr_sh;
	logic [BUF_BITS-1:0]   rec_sh;
	logic [8:0]            hdr_mdb;
	logic [7:0]            hdr_scfsi;
	gr_rec_t               rec;
	logic [1:0]            slot;
	logic [3:0]            ch_scfsi;
	logic [2:0]            ns_inc;

	assign s2_free       = !valid_s2 || m_axis_tready;
	assign adv           = valid_s1 && s2_free;
	assign s_axis_tready = !valid_s1 || s2_free;

	assign start   = user_s1[0];
	assign act     = start || active_q;
	assign bc0     = start ? '0 : bit_count_q;
	assign hd0     = start ? 1'b0 : header_done_q;
	assign ns0     = start ? 3'd0 : next_slot_q;
	assign mm      = start ? user_s1[1] : mono_q;
	assign hdr_len = mm ? HDR_BITS_MONO : HDR_BITS_STRO;
	assign recs    = mm ? RECS_MONO : RECS_STRO;
	assign buf_n   = {buf_q[BUF_BITS-9:0], byte_s1};
	assign bc1     = bc0 + BYTE_BITS;

	assign hdr_take  = !hd0 && (bc1 >= hdr_len);
	assign hdr_sh    = buf_n >> (bc1 - hdr_len);
	assign hdr_mdb   = mm ? hdr_sh[17:9] : hdr_sh[19:11];
	assign hdr_scfsi = mm ? {hdr_sh[3:0], 4'd0} : hdr_sh[7:0];
	assign bc2       = hdr_take ? (bc1 - hdr_len) : bc1;

	assign rec_take = act && (bc2 >= REC_BITS_C) && (ns0 < recs);
	assign rec_sh   = buf_n >> (bc2 - REC_BITS_C);
	assign rec      = unpack_record(rec_sh[REC_BITS-1:0]);
	assign ns_inc   = ns0 + 3'd1;

	always_comb begin
		if (mm) begin
			slot     = {ns0[0], 1'b0};
			ch_scfsi = scfsi_q[7:4];
		end else begin
			slot     = ns0[1:0];
			ch_scfsi = ns0[0] ? scfsi_q[3:0] : scfsi_q[7:4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			user_s1 <= s_axis_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q   <= '0;
			header_done_q <= 1'b0;
			next_slot_q   <= '0;
			mono_q        <= 1'b0;
			active_q      <= 1'b0;
			mdb_q         <= '0;
			scfsi_q       <= '0;
		end else if (adv && act) begin
			bit_count_q   <= rec_take ? (bc2 - REC_BITS_C) : bc2;
			header_done_q <= hd0 || hdr_take;
			next_slot_q   <= rec_take ? ns_inc : ns0;
			mono_q        <= mm;
			active_q      <= !(rec_take && (ns_inc >= recs));
			if (hdr_take) begin
				mdb_q   <= hdr_mdb;
				scfsi_q <= hdr_scfsi;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && act) begin
			buf_q <= buf_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= adv && rec_take;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && rec_take) begin
			user_s2 <= slot;
			data_s2 <= {3'd0, rec.region_counts, rec.subblock_gains, rec.table_selects,
				rec.flags, rec.block_type, rec.scalefac_compress, rec.global_gain,
				rec.big_values, rec.part2_3_length, ch_scfsi, mdb_q};
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;
	assign m_axis_tuser  = user_s2;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q <= BUF_BITS[CNT_W-1:0])
		else $error("bit count exceeds buffer");

	a_done_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(!active_q && header_done_q) |-> (next_slot_q == (mono_q ? RECS_MONO : RECS_STRO)))
		else $error("frame ended early");

	a_hdr_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(header_done_q) |-> $past(adv && start))
		else $error("header state cleared without frame start");

	a_rec_after_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && rec_take) |-> hd0)
		else $error("record taken before header");

endmodule

`default_nettype wire

// ===== sim/tb_mp3_side_info_parser.sv =====
// Testbench for mp3_side_info_parser: random and directed side-info byte streams,
// with a bit-level predictor checked against every emitted granule record.
// Depends on mp3si_pkg and the mp3_side_info_parser RTL.
`timescale 1ns / 1ps

module tb_mp3_side_info_parser;
	import mp3si_pkg::*;

	localparam int unsigned RANDOM_BYTES = 1800;
	localparam int unsigned QUIET_LIMIT  = 4000;
	localparam int unsigned MONO_BYTES   = 17;
	localparam int unsigned STRO_BYTES   = 32;

	typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_mode_t;

	typedef struct {
		logic [7:0] data;
		logic       start;
		logic       mono;
	} sideinfo_byte_t;

	// m_axis_tdata layout, highest field first
	typedef struct packed {
		logic [2:0]  pad;
		logic [7:0]  region_counts;
		logic [8:0]  subblock_gains;
		logic [14:0] table_selects;
		logic [4:0]  flags;
		logic [1:0]  block_type;
		logic [3:0]  scalefac_compress;
		logic [7:0]  global_gain;
		logic [8:0]  big_values;
		logic [11:0] part2_3_length;
		logic [3:0]  scfsi;
		logic [8:0]  main_data_begin;
	} side_info_rec_t;

	typedef struct {
		logic [1:0]     slot;
		side_info_rec_t rec;
	} granule_out_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = '0;
	logic [1:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;

	sideinfo_byte_t byte_queue[$];
	granule_out_t   expected_granules[$];
	bit             frame_bits[$];

	int unsigned total_bytes;
	int unsigned frame_byte_count;
	int unsigned sent_count;
	int unsigned phase = 0;
	int unsigned quiet_cycles;
	int unsigned errors = 0;

	// predictor state
	logic [BUF_BITS-1:0] bitbuf;
	int unsigned         bits_held;
	bit                  hdr_done;
	int unsigned         rec_idx;
	bit                  is_mono;
	bit                  in_frame;
	logic [8:0]          frame_mdb;
	logic [7:0]          frame_scfsi;
	int unsigned         cursor;

	sideinfo_byte_t drv_item;
	granule_out_t   want;
	side_info_rec_t got;

	mp3_side_info_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #10 clk = ~clk;

	function automatic int unsigned pull(int unsigned n);
		int unsigned v = 0;
		for (int k = 0; k < n; k++) begin
			if (cursor > 0)
				cursor--;
			v = (v << 1) | bitbuf[cursor];
		end
		return v;
	endfunction

	function automatic void parse_side_info_byte(input logic [7:0] b, input logic start,
			input logic mono_in);
		granule_out_t g;
		int unsigned  ws;
		int unsigned  bt;
		int unsigned  mixed;
		int unsigned  r0;
		int unsigned  r1;
		logic         pre_bit;
		logic         sfs_bit;
		logic         c1_bit;
		if (start) begin
			bits_held = 0;
			hdr_done  = 1'b0;
			rec_idx   = 0;
			is_mono   = mono_in;
			in_frame  = 1'b1;
			bitbuf    = '0;
		end
		if (!in_frame)
			return;
		bitbuf = {bitbuf[BUF_BITS-9:0], b};
		bits_held += BYTE_BITS;
		if (!hdr_done) begin
			if (bits_held < (is_mono ? HDR_BITS_MONO : HDR_BITS_STRO))
				return;
			cursor    = bits_held;
			frame_mdb = 9'(pull(9));
			void'(pull(is_mono ? 5 : 3));
			frame_scfsi = 8'(is_mono ? (pull(4) << 4) : pull(8));
			bits_held = cursor;
			hdr_done  = 1'b1;
		end
		if (bits_held < REC_BITS || rec_idx >= (is_mono ? RECS_MONO : RECS_STRO))
			return;
		cursor = bits_held;
		g.rec.pad               = '0;
		g.rec.part2_3_length    = 12'(pull(12));
		g.rec.big_values        = 9'(pull(9));
		g.rec.global_gain       = 8'(pull(8));
		g.rec.scalefac_compress = 4'(pull(4));
		ws = pull(1);
		if (ws) begin
			bt    = pull(2);
			mixed = pull(1);
			g.rec.table_selects  = 15'(pull(10) << 5);
			g.rec.subblock_gains = 9'(pull(9));
			r0 = (bt == BT_SHORT && !mixed) ? R0_SHORT : R0_OTHER;
			r1 = REGION_SUM - r0;
		end else begin
			bt    = 0;
			mixed = 0;
			g.rec.table_selects  = 15'(pull(15));
			g.rec.subblock_gains = '0;
			r0 = pull(4);
			r1 = pull(3);
		end
		pre_bit = 1'(pull(1));
		sfs_bit = 1'(pull(1));
		c1_bit  = 1'(pull(1));
		g.rec.block_type    = 2'(bt);
		g.rec.region_counts = {r0[3:0], r1[3:0]};
		g.rec.flags         = {ws[0], mixed[0], pre_bit, sfs_bit, c1_bit};
		bits_held = cursor;
		// mono frames have one channel: granule n sits in slot 2n
		g.slot = 2'(is_mono ? rec_idx * 2 : rec_idx);
		g.rec.main_data_begin = frame_mdb;
		g.rec.scfsi = g.slot[0] ? frame_scfsi[3:0] : frame_scfsi[7:4];
		expected_granules.push_back(g);
		rec_idx++;
		if (rec_idx >= (is_mono ? RECS_MONO : RECS_STRO))
			in_frame = 1'b0;
	endfunction

	function automatic int unsigned pick_field(int unsigned w, fill_mode_t mode);
		int unsigned mask = (1 << w) - 1;
		int unsigned r = $urandom_range(7);
		if (mode == FILL_ZEROS)
			return 0;
		if (mode == FILL_ONES)
			return mask;
		if (r == 0)
			return 0;
		if (r == 1)
			return mask;
		return $urandom & mask;
	endfunction

	function automatic void push_bits(int unsigned v, int unsigned w);
		for (int i = w - 1; i >= 0; i--)
			frame_bits.push_back(v[i]);
	endfunction

	task automatic add_stray(int unsigned n);
		sideinfo_byte_t item;
		for (int i = 0; i < n; i++) begin
			item.data  = 8'($urandom);
			item.start = 1'b0;
			item.mono  = 1'($urandom_range(1));
			byte_queue.push_back(item);
		end
	endtask

	// keep < full length gives an incomplete frame
	task automatic add_frame(bit mono, fill_mode_t mode, int unsigned keep);
		sideinfo_byte_t item;
		int unsigned    ws;
		frame_bits.delete();
		push_bits(pick_field(9, mode), 9);
		push_bits(pick_field(mono ? 5 : 3, mode), mono ? 5 : 3);
		push_bits(pick_field(mono ? 4 : 8, mode), mono ? 4 : 8);
		for (int r = 0; r < (mono ? RECS_MONO : RECS_STRO); r++) begin
			push_bits(pick_field(12, mode), 12);
			push_bits(pick_field(9, mode), 9);
			push_bits(pick_field(8, mode), 8);
			push_bits(pick_field(4, mode), 4);
			ws = (mode == FILL_RANDOM) ? $urandom_range(1) : pick_field(1, mode);
			push_bits(ws, 1);
			if (ws) begin
				push_bits((mode == FILL_RANDOM) ? $urandom_range(3) : pick_field(2, mode), 2);
				push_bits(pick_field(1, mode), 1);
				push_bits(pick_field(10, mode), 10);
				push_bits(pick_field(9, mode), 9);
			end else begin
				push_bits(pick_field(15, mode), 15);
				push_bits(pick_field(4, mode), 4);
				push_bits(pick_field(3, mode), 3);
			end
			push_bits(pick_field(3, mode), 3);
		end
		for (int i = 0; i < keep; i++) begin
			for (int k = 0; k < 8; k++)
				item.data[7-k] = frame_bits[8*i+k];
			item.start = (i == 0);
			item.mono  = (i == 0) ? mono : 1'($urandom_range(1));
			byte_queue.push_back(item);
		end
		frame_byte_count += keep;
	endtask

	function automatic int unsigned sender_gap_pct();
		case (phase)
			0: return 12;
			1: return 60;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned receiver_stall_pct();
		case (phase)
			0: return 60;
			1: return 12;
			default: return 0;
		endcase
	endfunction

	task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
		if (act !== exp) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
			errors++;
		end
	endtask

	// driver: one request per byte, predictor runs on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				parse_side_info_byte(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1]);
				sent_count++;
				phase <= (sent_count * 3) / total_bytes;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (byte_queue.size() != 0 && $urandom_range(99) >= sender_gap_pct()) begin
					drv_item = byte_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= drv_item.data;
					s_axis_tuser  <= {drv_item.mono, drv_item.start};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = side_info_rec_t'(m_axis_tdata);
				if (expected_granules.size() == 0) begin
					$display("%0t: unexpected record, expected none, actual slot %0d data %h",
						$time, m_axis_tuser, m_axis_tdata);
					errors++;
				end else begin
					want = expected_granules.pop_front();
					check_field("slot", want.slot, m_axis_tuser);
					check_field("main_data_begin", want.rec.main_data_begin,
						got.main_data_begin);
					check_field("scfsi", want.rec.scfsi, got.scfsi);
					check_field("part2_3_length", want.rec.part2_3_length, got.part2_3_length);
					check_field("big_values", want.rec.big_values, got.big_values);
					check_field("global_gain", want.rec.global_gain, got.global_gain);
					check_field("scalefac_compress", want.rec.scalefac_compress,
						got.scalefac_compress);
					check_field("block_type", want.rec.block_type, got.block_type);
					check_field("flags", want.rec.flags, got.flags);
					check_field("table_selects", want.rec.table_selects, got.table_selects);
					check_field("subblock_gains", want.rec.subblock_gains, got.subblock_gains);
					check_field("region_counts", want.rec.region_counts, got.region_counts);
					check_field("pad", want.rec.pad, got.pad);
				end
			end
			m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct());
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned pick;
		bit          mono;
		frame_byte_count = 0;
		sent_count       = 0;
		quiet_cycles     = 0;
		bitbuf           = '0;
		bits_held        = 0;
		hdr_done         = 1'b0;
		rec_idx          = 0;
		is_mono          = 1'b0;
		in_frame         = 1'b0;
		frame_mdb        = '0;
		frame_scfsi      = '0;

		// bytes before any frame, full mono frame at maximum values, trailing bytes,
		// then an all-zero stereo frame cut short by the next start and a full all-zero stereo frame
		add_stray(2);
		add_frame(1'b1, FILL_ONES, MONO_BYTES);
		add_stray(2);
		add_frame(1'b0, FILL_ZEROS, 5);
		add_frame(1'b0, FILL_ZEROS, STRO_BYTES);
		frame_byte_count = 0;

		while (frame_byte_count < RANDOM_BYTES) begin
			pick = $urandom_range(99);
			mono = 1'($urandom_range(1));
			if (pick < 8)
				add_stray($urandom_range(1, 4));
			else if (pick < 18)
				add_frame(mono, FILL_RANDOM,
					$urandom_range(1, (mono ? MONO_BYTES : STRO_BYTES) - 1));
			else
				add_frame(mono, FILL_RANDOM, mono ? MONO_BYTES : STRO_BYTES);
		end
		total_bytes = byte_queue.size();

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (byte_queue.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (expected_granules.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/mp3si_pkg.sv
hw/rtl/mp3_side_info_parser.sv
sim/tb_mp3_side_info_parser.sv
